// File: src/g2g_pkg.sv
// ----------------------------------------------------------------------------
// g2g_pkg
// Shared types, constants and the arctangent table of the go-to-goal
// controller.
// ----------------------------------------------------------------------------
package g2g_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  // angle widths inside the datapath (Q2.29 in ZW and EW, 13 fraction bits in E13W)
  localparam int ZW   = 34;
  localparam int EW   = 36;
  localparam int E13W = EW - 16;

  localparam int ADDR_W = 4;

  localparam int          PI_Q29    = 1686629713;
  localparam logic [15:0] KCOMP_Q16 = 16'd39796;
  localparam logic [30:0] SPEED_MAX = '1;

  localparam logic [15:0] LINEAR_GAIN_RST  = 16'd32768;
  localparam logic [15:0] ANGULAR_GAIN_RST = 16'd32768;
  localparam logic [30:0] DIST_TOL_RST     = 31'd6554;
  localparam logic [14:0] ANGLE_TOL_RST    = 15'd819;

  typedef enum logic {
    CMD_WAYPOINT = 1'b0,
    CMD_POSE     = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LINEAR_GAIN  = 2'd0,
    REG_ANGULAR_GAIN = 2'd1,
    REG_DIST_TOL     = 2'd2,
    REG_ANGLE_TOL    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROTATE,
    ST_SCALE,
    ST_ERROR,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } item_t;

  typedef struct packed {
    logic [30:0]        linear_speed;
    logic signed [15:0] angular_rate;
    logic               goal_reached;
  } result_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [30:0] distance_tolerance;
    logic [14:0] angle_tolerance;
  } cfg_t;

  // atan(2^-i) in Q2.29, rounded to nearest
  function automatic logic [31:0] atan_q29(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:         v = 32'd421657428;
      5'd1:         v = 32'd248918915;
      5'd2:         v = 32'd131521918;
      5'd3:         v = 32'd66762579;
      5'd4:         v = 32'd33510843;
      5'd5:         v = 32'd16771758;
      5'd6:         v = 32'd8387925;
      5'd7:         v = 32'd4194219;
      5'd8:         v = 32'd2097141;
      5'd9:         v = 32'd1048575;
      5'd30, 5'd31: v = '0;
      default:      v = 32'd1 << (5'd29 - idx);
    endcase
    return v;
  endfunction

endpackage

// File: src/go_to_goal_controller_top.sv
// Waypoint item: no result; the next item may follow at once.
// Pose item: the sequencer steps through load, rotate, scale, error, decide and finish;
// the result is registered from finish, and the next item is stalled until idle again.
// A waiting result holds the sequencer in its last step until the result transfer.
// Synchronous active-high reset: goal at origin, not armed, registers at defaults.
// ----------------------------------------------------------------------------
// go_to_goal_controller_top
// Rotate-then-drive proportional go-to-goal controller with APB register port.
// ----------------------------------------------------------------------------
module go_to_goal_controller_top
  import g2g_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item_data,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     eng_busy, eng_push, res_ready, start;
  result_t  eng_res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_gain        <= LINEAR_GAIN_RST;
      cfg.angular_gain       <= ANGULAR_GAIN_RST;
      cfg.distance_tolerance <= DIST_TOL_RST;
      cfg.angle_tolerance    <= ANGLE_TOL_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_LINEAR_GAIN:  cfg.linear_gain        <= pwdata[15:0];
        REG_ANGULAR_GAIN: cfg.angular_gain       <= pwdata[15:0];
        REG_DIST_TOL:     cfg.distance_tolerance <= pwdata[30:0];
        REG_ANGLE_TOL:    cfg.angle_tolerance    <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINEAR_GAIN:  prdata = {16'b0, cfg.linear_gain};
      REG_ANGULAR_GAIN: prdata = {16'b0, cfg.angular_gain};
      REG_DIST_TOL:     prdata = {1'b0, cfg.distance_tolerance};
      REG_ANGLE_TOL:    prdata = {17'b0, cfg.angle_tolerance};
    endcase
  end

  assign item_stall = eng_busy;
  assign start      = item_valid && !item_stall;
  assign res_ready  = !result_valid || !result_stall;

  g2g_engine #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item_data),
    .cfg       (cfg),
    .res_ready (res_ready),
    .busy      (eng_busy),
    .res_push  (eng_push),
    .res       (eng_res)
  );

  // output register; frees the engine while a result waits for transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (eng_push) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_push) begin
      result_data <= eng_res;
    end
  end

endmodule

// File: src/g2g_engine.sv
// ----------------------------------------------------------------------------
// g2g_engine
// Sequencer and shared datapath: goal store, CORDIC vectoring over one
// shift/add unit, one shared multiplier for scaling and gains.
// ----------------------------------------------------------------------------
module g2g_engine
  import g2g_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  input  cfg_t    cfg,
  input  logic    res_ready,
  output logic    busy,
  output logic    res_push,
  output result_t res
);

  localparam int XW = COORD_WIDTH + 3;
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int MW = (XW > E13W) ? XW : E13W;
  localparam int PW = MW + 18;
  localparam int RW = PW - 16;
  localparam int QW = (RW > 33) ? RW : 33;
  localparam int TW = (XW > 31) ? XW : 31;

  localparam logic signed [ZW-1:0] PI_Z     = ZW'(PI_Q29);
  localparam logic signed [EW-1:0] PI_E     = EW'(PI_Q29);
  localparam logic signed [EW-1:0] TWO_PI_E = PI_E <<< 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(32768);
  localparam logic signed [QW-1:0] Q_SPEED_MAX = $signed(QW'(SPEED_MAX));
  localparam logic signed [QW-1:0] Q_RATE_MAX  = QW'(32'sd32767);
  localparam logic signed [QW-1:0] Q_RATE_MIN  = QW'(-32'sd32768);
  localparam logic [SW-1:0]        LAST_STEP   = SW'(CORDIC_STEPS - 1);

  state_t state, state_next;

  logic signed [COORD_WIDTH-1:0] goal_x, goal_y;
  logic                          goal_active;
  logic signed [COORD_WIDTH-1:0] px, py, in_x, in_y;
  logic signed [15:0]            hd;
  logic signed [XW-1:0]          x, y;
  logic signed [ZW-1:0]          z;
  logic [SW-1:0]                 cnt;
  logic signed [PW-1:0]          prod;
  logic [XW-1:0]                 goal_dist;
  logic signed [EW-1:0]          err;
  logic signed [E13W-1:0]        err13;
  logic                          far, turn;

  logic signed [MW-1:0]  mul_a;
  logic signed [17:0]    mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [RW-1:0]  q;
  logic signed [QW-1:0]  qx;
  logic signed [XW-1:0]  dx, dy, xs, ys;
  logic signed [ZW-1:0]  at;
  logic signed [EW-1:0]  err_raw, err_wrap, err_rnd;
  logic [E13W-1:0]       mag;
  logic                  far_n, turn_n;

  // coordinates narrower than the field use its low bits, wider ones extend it
  if (COORD_WIDTH <= 32) begin : g_narrow
    assign in_x = $signed(item.pos_x[COORD_WIDTH-1:0]);
    assign in_y = $signed(item.pos_y[COORD_WIDTH-1:0]);
  end else begin : g_wide
    assign in_x = $signed({{(COORD_WIDTH-32){1'b0}}, item.pos_x});
    assign in_y = $signed({{(COORD_WIDTH-32){1'b0}}, item.pos_y});
  end

  // shared datapath terms
  always_comb begin
    dx      = XW'(goal_x) - XW'(px);
    dy      = XW'(goal_y) - XW'(py);
    xs      = x >>> cnt;
    ys      = y >>> cnt;
    at      = $signed(ZW'(atan_q29(5'(cnt))));
    err_raw = EW'(z) - $signed({{(EW-32){hd[15]}}, hd, 16'b0});
    if (err > PI_E) begin
      err_wrap = err - TWO_PI_E;
    end else if (err < -PI_E) begin
      err_wrap = err + TWO_PI_E;
    end else begin
      err_wrap = err;
    end
    err_rnd = err_wrap + EW'(32768);
    mag     = err13[E13W-1] ? E13W'(-err13) : E13W'(err13);
    far_n   = goal_active && (TW'(goal_dist) > TW'(cfg.distance_tolerance));
    turn_n  = mag > E13W'(cfg.angle_tolerance);
    mul_p   = mul_a * mul_b;
    q       = RW'((prod + RND_HALF) >>> 16);
    qx      = QW'(q);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start && item.command == CMD_POSE) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROTATE;
      ST_ROTATE: if (cnt == LAST_STEP) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ERROR;
      ST_ERROR:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_FINISH;
      ST_FINISH: if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs and multiplier operand selection
  always_comb begin
    busy     = (state != ST_IDLE);
    res_push = (state == ST_FINISH) && res_ready;
    mul_a    = MW'(x);
    mul_b    = $signed({2'b00, KCOMP_Q16});
    if (state == ST_DECIDE) begin
      if (turn_n) begin
        mul_a = MW'(err13);
        mul_b = $signed({2'b00, cfg.angular_gain});
      end else begin
        mul_a = $signed(MW'(goal_dist));
        mul_b = $signed({2'b00, cfg.linear_gain});
      end
    end
  end

  // result formatting from the last product
  always_comb begin
    res.linear_speed = '0;
    res.angular_rate = '0;
    res.goal_reached = !far;
    if (far) begin
      if (turn) begin
        if (qx > Q_RATE_MAX) begin
          res.angular_rate = 16'sh7FFF;
        end else if (qx < Q_RATE_MIN) begin
          res.angular_rate = 16'sh8000;
        end else begin
          res.angular_rate = qx[15:0];
        end
      end else begin
        res.linear_speed = (qx > Q_SPEED_MAX) ? SPEED_MAX : qx[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      goal_x      <= '0;
      goal_y      <= '0;
      goal_active <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start && item.command == CMD_WAYPOINT) begin
        goal_x      <= in_x;
        goal_y      <= in_y;
        goal_active <= 1'b1;
      end
      if (state == ST_DECIDE && !far_n) begin
        goal_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        px  <= in_x;
        py  <= in_y;
        hd  <= item.heading;
        cnt <= '0;
      end
      ST_LOAD: begin
        // left half plane: rotate by pi first
        if (dx[XW-1]) begin
          x <= -dx;
          y <= -dy;
          z <= dy[XW-1] ? -PI_Z : PI_Z;
        end else begin
          x <= dx;
          y <= dy;
          z <= '0;
        end
      end
      ST_ROTATE: begin
        if (!y[XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        cnt <= cnt + 1'b1;
      end
      ST_SCALE: begin
        prod <= mul_p;
        err  <= err_raw;
      end
      ST_ERROR: begin
        goal_dist <= q[XW-1:0];
        err13     <= err_rnd[EW-1:16];
      end
      ST_DECIDE: begin
        prod <= mul_p;
        far  <= far_n;
        turn <= turn_n;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

endmodule
